>>> rtl/bitstream_word_reader_top_macros.svh
// assertion macros for the bit stream word reader
// the asserting module provides clk_i and rst_ni
`ifndef BITSTREAM_WORD_READER_TOP_MACROS_SVH
`define BITSTREAM_WORD_READER_TOP_MACROS_SVH

// condition implies property in the same cycle
`define BWR_ASSERT_IMP(name, cond, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (prop)) \
    else $error(msg);

// condition implies property in the next cycle
`define BWR_ASSERT_NXT(name, cond, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (prop)) \
    else $error(msg);

`endif

>>> rtl/bwr_pkg.sv
`default_nettype none
package bwr_pkg;

  localparam logic [2:0] CMD_WRITE    = 3'd0;
  localparam logic [2:0] CMD_SEEK     = 3'd1;
  localparam logic [2:0] CMD_SEEK_AL  = 3'd2;
  localparam logic [2:0] CMD_FIXED    = 3'd3;
  localparam logic [2:0] CMD_UNARY    = 3'd4;
  localparam logic [2:0] CMD_NEXT     = 3'd5;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_LEN   = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  // register index decoded from paddr[2]
  localparam logic CFG_WORDS_IN_USE = 1'b0;
  localparam logic [10:0] WORDS_IN_USE_RST = 11'd1024;

  typedef enum logic [2:0] {
    OP_WRITE,
    OP_SEEK,
    OP_SEEK_AL,
    OP_FIXED,
    OP_UNARY,
    OP_NEXT,
    OP_NONE
  } op_e;

  typedef struct packed {
    op_e         op;
    logic        len_err;
    logic [9:0]  addr;
    logic [63:0] data;
    logic [6:0]  len;
    logic [15:0] seek;
  } req_t;

endpackage
`default_nettype wire

>>> rtl/bitstream_word_reader_top.sv
// channel   direction  handshake               payload
// request   in         in_valid_i/in_stall_o   cmd, word_address, word_data, field_length,
//                                              seek_position
// result    out        out_valid_o/out_stall_i value, bit_position, status
// config    in         apb psel/penable/pwrite words_in_use at byte address 0
//
// a two-entry request queue takes a request every cycle until full; results leave
// through a result register, so the queue keeps filling while a result is stalled
// write, seek and unknown finish in the executor's idle state; aligned seek reads the
// store in S_SARD; a fixed read runs S_FIX, refilling through S_FLO, and S_FHI when two
// words join; unary runs S_UCHK, S_FIND, S_UAPP; next reads S_NRD per all-zero word
// reset clears buffer, position and queue; the word store has no reset and no clear pass
`default_nettype none
module bitstream_word_reader_top #(
  parameter int unsigned STORE_WORDS = 1024
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  // request channel
  input  wire logic         in_valid_i,
  output logic              in_stall_o,
  input  wire logic [2:0]   cmd_i,
  input  wire logic [9:0]   word_address_i,
  input  wire logic [63:0]  word_data_i,
  input  wire logic [6:0]   field_length_i,
  input  wire logic [15:0]  seek_position_i,
  // result channel
  output logic              out_valid_o,
  input  wire logic         out_stall_i,
  output logic [63:0]       value_o,
  output logic [16:0]       bit_position_o,
  output logic [1:0]        status_o,
  // configuration port
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [2:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import bwr_pkg::*;

  logic [10:0] words_in_use_q;
  logic        req_valid;
  req_t        req;
  logic        pop;

  // configuration register: only bit 2 of the byte address selects a register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == CFG_WORDS_IN_USE) ? {21'd0, words_in_use_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      words_in_use_q <= WORDS_IN_USE_RST;
    end else if (psel && penable && pwrite && pready && (paddr[2] == CFG_WORDS_IN_USE)) begin
      words_in_use_q <= pwdata[10:0];
    end
  end

  // front: accept and classify requests into the queue
  bwr_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .cmd_i           (cmd_i),
    .word_address_i  (word_address_i),
    .word_data_i     (word_data_i),
    .field_length_i  (field_length_i),
    .seek_position_i (seek_position_i),
    .req_valid_o     (req_valid),
    .req_o           (req),
    .pop_i           (pop)
  );

  // back: owns the word store and the bit buffer, runs one request at a time
  bwr_back #(
    .STORE_WORDS (STORE_WORDS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_valid_i    (req_valid),
    .req_i          (req),
    .pop_o          (pop),
    .words_in_use_i (words_in_use_q),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .value_o        (value_o),
    .bit_position_o (bit_position_o),
    .status_o       (status_o)
  );

endmodule
`default_nettype wire

>>> rtl/bwr_ram.sv
`default_nettype none
module bwr_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

>>> rtl/bwr_front.sv
`default_nettype none
module bwr_front (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_stall_o,
  input  wire logic [2:0]   cmd_i,
  input  wire logic [9:0]   word_address_i,
  input  wire logic [63:0]  word_data_i,
  input  wire logic [6:0]   field_length_i,
  input  wire logic [15:0]  seek_position_i,
  output logic              req_valid_o,
  output bwr_pkg::req_t     req_o,
  input  wire logic         pop_i
);
  import bwr_pkg::*;

  req_t       entry_q [2];
  req_t       new_req;
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] count_q;
  logic       push;

  // classify the command
  always_comb begin
    new_req.addr    = word_address_i;
    new_req.data    = word_data_i;
    new_req.len     = field_length_i;
    new_req.seek    = seek_position_i;
    new_req.len_err = field_length_i[6];
    unique case (cmd_i)
      CMD_WRITE:   new_req.op = OP_WRITE;
      CMD_SEEK:    new_req.op = OP_SEEK;
      CMD_SEEK_AL: new_req.op = OP_SEEK_AL;
      CMD_FIXED:   new_req.op = OP_FIXED;
      CMD_UNARY:   new_req.op = OP_UNARY;
      CMD_NEXT:    new_req.op = OP_NEXT;
      default:     new_req.op = OP_NONE;
    endcase
  end

  assign in_stall_o  = (count_q == 2'd2);
  assign push        = in_valid_i && !in_stall_o;
  assign req_valid_o = (count_q != 2'd0);
  assign req_o       = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= new_req;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push && !pop_i) begin
        count_q <= count_q + 2'd1;
      end else if (pop_i && !push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/bwr_back.sv
`default_nettype none
module bwr_back #(
  parameter int unsigned STORE_WORDS = 1024
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          req_valid_i,
  input  bwr_pkg::req_t      req_i,
  output logic               pop_o,
  input  wire logic [10:0]   words_in_use_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output logic [63:0]        value_o,
  output logic [16:0]        bit_position_o,
  output logic [1:0]         status_o
);
  import bwr_pkg::*;

  localparam int unsigned ADDR_W = $clog2(STORE_WORDS);
  localparam int unsigned BLK_W  = ADDR_W + 1;
  localparam int unsigned POS_W  = BLK_W + 6;
  localparam int unsigned CMP_W  = (BLK_W > 11) ? BLK_W : 11;
  localparam int unsigned SK_W   = (POS_W > 16) ? POS_W : 16;
  localparam int unsigned AC_W   = (BLK_W > 10) ? BLK_W : 10;
  localparam int unsigned PX_W   = (POS_W > 17) ? POS_W : 17;

  typedef enum logic [3:0] {
    S_IDLE, S_FIX, S_FLO, S_FHI, S_UCHK, S_NCHK, S_NRD, S_FIND, S_UAPP, S_NAPP, S_SARD
  } state_e;

  function automatic logic [5:0] low_one(input logic [63:0] x);
    logic [5:0] n;
    n = 6'd63;
    for (int i = 63; i >= 0; i--) begin
      if (x[i]) n = 6'(i);
    end
    return n;
  endfunction

  state_e            state_q, state_d;
  logic [63:0]       buf_q, buf_d;
  logic [6:0]        av_q, av_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic [63:0]       wbuf_q, wbuf_d;
  logic [6:0]        wav_q, wav_d;
  logic [POS_W-1:0]  wpos_q, wpos_d;
  logic [POS_W-1:0]  zeros_q, zeros_d;
  logic [63:0]       lo_q, lo_d;
  logic [5:0]        l_q, l_d;
  req_t              cur_q, cur_d;
  logic              out_valid_q;
  logic [63:0]       out_value_q;
  logic [16:0]       out_pos_q;
  logic [1:0]        out_status_q;

  logic              emit;
  logic [63:0]       val_d;
  logic [1:0]        st_d;
  logic [PX_W-1:0]   pos_ext;

  logic [BLK_W-1:0]  vw;
  logic [CMP_W-1:0]  wiu_ext;
  logic [POS_W-1:0]  end_bits;
  logic [SK_W-1:0]   seek_w;
  logic              seek_bad;
  logic              addr_ok;
  logic              start;
  logic [BLK_W-1:0]  wblk;
  logic [5:0]        wsh;
  logic [BLK_W:0]    blk1;
  logic [POS_W-1:0]  upos;
  logic [BLK_W-1:0]  ublk;
  logic [POS_W-1:0]  npos;
  logic [BLK_W-1:0]  nblk;
  logic [6:0]        lp1;
  logic [63:0]       mask;
  state_e            ret_state;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_addr;
  logic [63:0]       ram_rdata;

  bwr_ram #(
    .WIDTH (64),
    .DEPTH (STORE_WORDS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (req_i.data),
    .rdata_o (ram_rdata)
  );

  // words in use, limited to the store size
  assign wiu_ext  = CMP_W'(words_in_use_i);
  assign vw       = (wiu_ext > CMP_W'(STORE_WORDS)) ? BLK_W'(STORE_WORDS) : BLK_W'(wiu_ext);
  assign end_bits = {vw, 6'd0};
  assign seek_w   = SK_W'(req_i.seek);
  assign seek_bad = seek_w >= SK_W'(end_bits);
  assign addr_ok  = AC_W'(req_i.addr) < AC_W'(STORE_WORDS);
  assign start    = req_valid_i && (!out_valid_q || !out_stall_i);

  assign wblk = wpos_q[POS_W-1:6];
  assign wsh  = wpos_q[5:0];
  assign blk1 = {1'b0, wblk} + (BLK_W+1)'(1);
  assign upos = wpos_q + POS_W'(wav_q);
  assign ublk = upos[POS_W-1:6];
  assign npos = wpos_q + POS_W'(64);
  assign nblk = npos[POS_W-1:6];
  assign lp1  = {1'b0, l_q} + 7'd1;
  assign mask = (64'd1 << cur_q.len[5:0]) - 64'd1;
  assign ret_state = (cur_q.op == OP_FIXED) ? S_FIX : S_UCHK;

  always_comb begin
    state_d  = state_q;
    buf_d    = buf_q;
    av_d     = av_q;
    pos_d    = pos_q;
    wbuf_d   = wbuf_q;
    wav_d    = wav_q;
    wpos_d   = wpos_q;
    zeros_d  = zeros_q;
    lo_d     = lo_q;
    l_d      = l_q;
    cur_d    = cur_q;
    emit     = 1'b0;
    val_d    = 64'd0;
    st_d     = ST_OK;
    pop_o    = 1'b0;
    ram_we   = 1'b0;
    ram_addr = wblk[ADDR_W-1:0];
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          pop_o = 1'b1;
          cur_d = req_i;
          unique case (req_i.op)
            OP_WRITE: begin
              ram_we   = addr_ok;
              ram_addr = ADDR_W'(req_i.addr);
              emit     = 1'b1;
            end
            OP_SEEK: begin
              emit = 1'b1;
              if (seek_bad) begin
                st_d = ST_RANGE;
              end else begin
                pos_d = POS_W'(req_i.seek);
                buf_d = 64'd0;
                av_d  = 7'd0;
              end
            end
            OP_SEEK_AL: begin
              if (seek_bad) begin
                emit = 1'b1;
                st_d = ST_RANGE;
              end else begin
                ram_addr = ADDR_W'(seek_w >> 6);
                state_d  = S_SARD;
              end
            end
            OP_FIXED: begin
              if (req_i.len_err) begin
                emit = 1'b1;
                st_d = ST_LEN;
              end else begin
                wbuf_d  = buf_q;
                wav_d   = av_q;
                wpos_d  = pos_q;
                state_d = S_FIX;
              end
            end
            OP_UNARY: begin
              wbuf_d  = buf_q;
              wav_d   = av_q;
              wpos_d  = pos_q;
              zeros_d = '0;
              state_d = S_UCHK;
            end
            OP_NEXT: begin
              wbuf_d  = buf_q;
              wpos_d  = pos_q;
              state_d = S_NCHK;
            end
            default: emit = 1'b1;
          endcase
        end
      end
      S_FIX: begin
        if (wav_q >= cur_q.len) begin
          emit    = 1'b1;
          val_d   = wbuf_q & mask;
          buf_d   = wbuf_q >> cur_q.len;
          av_d    = wav_q - cur_q.len;
          pos_d   = wpos_q + POS_W'(cur_q.len);
          state_d = S_IDLE;
        end else if (wblk >= vw) begin
          emit    = 1'b1;
          st_d    = ST_RANGE;
          state_d = S_IDLE;
        end else begin
          state_d = S_FLO;
        end
      end
      S_FLO: begin
        lo_d = ram_rdata;
        if ((wsh != 6'd0) && (blk1 < {1'b0, vw})) begin
          ram_addr = blk1[ADDR_W-1:0];
          state_d  = S_FHI;
        end else begin
          wbuf_d  = ram_rdata >> wsh;
          wav_d   = 7'd64;
          state_d = ret_state;
        end
      end
      S_FHI: begin
        // join the two words across the unaligned boundary
        wbuf_d  = (lo_q >> wsh) | (ram_rdata << (7'd64 - {1'b0, wsh}));
        wav_d   = 7'd64;
        state_d = ret_state;
      end
      S_UCHK: begin
        if (wbuf_q != 64'd0) begin
          state_d = S_FIND;
        end else if (ublk >= vw) begin
          emit    = 1'b1;
          st_d    = ST_RANGE;
          state_d = S_IDLE;
        end else begin
          wpos_d   = upos;
          zeros_d  = zeros_q + POS_W'(wav_q);
          ram_addr = ublk[ADDR_W-1:0];
          state_d  = S_FLO;
        end
      end
      S_NCHK: begin
        if (wbuf_q != 64'd0) begin
          state_d = S_FIND;
        end else if (nblk >= vw) begin
          emit    = 1'b1;
          st_d    = ST_RANGE;
          state_d = S_IDLE;
        end else begin
          wpos_d   = npos;
          ram_addr = nblk[ADDR_W-1:0];
          state_d  = S_NRD;
        end
      end
      S_NRD: begin
        wbuf_d  = ram_rdata;
        state_d = S_NCHK;
      end
      S_FIND: begin
        l_d     = low_one(wbuf_q);
        state_d = (cur_q.op == OP_UNARY) ? S_UAPP : S_NAPP;
      end
      S_UAPP: begin
        emit    = 1'b1;
        val_d   = 64'(zeros_q) + 64'(l_q);
        buf_d   = (wbuf_q >> l_q) >> 1;
        av_d    = (wav_q >= lp1) ? (wav_q - lp1) : 7'd0;
        pos_d   = wpos_q + POS_W'(lp1);
        state_d = S_IDLE;
      end
      S_NAPP: begin
        emit    = 1'b1;
        buf_d   = wbuf_q & (wbuf_q - 64'd1);
        pos_d   = {wpos_q[POS_W-1:6], l_q};
        state_d = S_IDLE;
      end
      S_SARD: begin
        emit    = 1'b1;
        buf_d   = ram_rdata & (~64'd0 << cur_q.seek[5:0]);
        pos_d   = POS_W'(cur_q.seek);
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign pos_ext = PX_W'(pos_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      buf_q        <= 64'd0;
      av_q         <= 7'd0;
      pos_q        <= '0;
      wbuf_q       <= 64'd0;
      wav_q        <= 7'd0;
      wpos_q       <= '0;
      zeros_q      <= '0;
      lo_q         <= 64'd0;
      l_q          <= 6'd0;
      cur_q        <= '0;
      out_valid_q  <= 1'b0;
      out_value_q  <= 64'd0;
      out_pos_q    <= 17'd0;
      out_status_q <= ST_OK;
    end else begin
      state_q <= state_d;
      buf_q   <= buf_d;
      av_q    <= av_d;
      pos_q   <= pos_d;
      wbuf_q  <= wbuf_d;
      wav_q   <= wav_d;
      wpos_q  <= wpos_d;
      zeros_q <= zeros_d;
      lo_q    <= lo_d;
      l_q     <= l_d;
      cur_q   <= cur_d;
      if (emit) begin
        out_valid_q  <= 1'b1;
        out_value_q  <= val_d;
        out_pos_q    <= pos_ext[16:0];
        out_status_q <= st_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign value_o        = out_value_q;
  assign bit_position_o = out_pos_q;
  assign status_o       = out_status_q;

endmodule
`default_nettype wire

>>> rtl/bwr_checker.sv
`default_nettype none
`include "bitstream_word_reader_top_macros.svh"
module bwr_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [63:0] value_o,
  input wire logic [16:0] bit_position_o,
  input wire logic [1:0]  status_o
);
  import bwr_pkg::*;

  `BWR_ASSERT_NXT(a_result_hold, out_valid_o && out_stall_i, out_valid_o && $stable(value_o) && $stable(bit_position_o) && $stable(status_o), "stalled result changed")
  `BWR_ASSERT_IMP(a_status_code, out_valid_o, status_o == ST_OK || status_o == ST_LEN || status_o == ST_RANGE, "bad status code")
  `BWR_ASSERT_IMP(a_error_value, out_valid_o && status_o != ST_OK, value_o == 64'd0, "error result with nonzero value")

endmodule

bind bitstream_word_reader_top bwr_checker u_bwr_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .value_o        (value_o),
  .bit_position_o (bit_position_o),
  .status_o       (status_o)
);
`default_nettype wire

>>> sim/bitstream_word_reader_top_tb.sv
`default_nettype none
module bitstream_word_reader_top_tb;

  localparam int unsigned STORE_WORDS = 1024;

  // one request as the sender builds it
  typedef struct {
    logic [2:0]  cmd;
    logic [9:0]  addr;
    logic [63:0] data;
    logic [6:0]  len;
    logic [15:0] seek;
  } word_request_t;

  typedef struct {
    logic [63:0] value;
    logic [16:0] bit_position;
    logic [1:0]  status;
  } reader_result_t;

  // stream reader mirror plus the queue of results it predicts
  class reader_scoreboard;
    logic [63:0]    words [STORE_WORDS];
    logic [63:0]    buffer;
    int unsigned    avail;
    int unsigned    rd_pos;
    logic [10:0]    words_in_use;
    reader_result_t pending_results[$];
    int             mismatches;

    function new();
      foreach (words[i]) words[i] = '0;
      buffer       = '0;
      avail        = 0;
      rd_pos       = 0;
      words_in_use = bwr_pkg::WORDS_IN_USE_RST;
      mismatches   = 0;
    endfunction

    function int unsigned live_words();
      return (words_in_use > STORE_WORDS) ? STORE_WORDS : words_in_use;
    endfunction

    function int unsigned lowest_one(logic [63:0] x);
      int unsigned n;
      n = 0;
      while (n < 63 && x[n] == 1'b0) n++;
      return n;
    endfunction

    // 64 bits from stream bit pos, joining two words when unaligned
    function bit fetch(int unsigned pos, output logic [63:0] word);
      int unsigned blk;
      int unsigned sh;
      blk  = pos >> 6;
      sh   = pos & 63;
      word = '0;
      if (blk >= live_words()) return 0;
      word = words[blk] >> sh;
      if (sh != 0 && blk + 1 < live_words()) word |= words[blk + 1] << (64 - sh);
      return 1;
    endfunction

    function void note_request(word_request_t rq);
      reader_result_t r;
      int unsigned    end_bits;
      logic [63:0]    buf_w;
      int unsigned    av;
      int unsigned    pos;
      int unsigned    l;
      logic [63:0]    zeros;
      bit             ok;
      end_bits = live_words() * 64;
      r.value  = '0;
      r.status = bwr_pkg::ST_OK;
      case (rq.cmd)
        bwr_pkg::CMD_WRITE: begin
          if (rq.addr < STORE_WORDS) words[rq.addr] = rq.data;
        end
        bwr_pkg::CMD_SEEK, bwr_pkg::CMD_SEEK_AL: begin
          if (rq.seek >= end_bits) begin
            r.status = bwr_pkg::ST_RANGE;
          end else begin
            rd_pos = rq.seek;
            if (rq.cmd == bwr_pkg::CMD_SEEK) begin
              buffer = '0;
              avail  = 0;
            end else begin
              // aligned word with the bits below the position cleared
              buffer = words[rq.seek >> 6] & ({64{1'b1}} << (rq.seek & 63));
            end
          end
        end
        bwr_pkg::CMD_FIXED: begin
          if (rq.len >= 64) begin
            r.status = bwr_pkg::ST_LEN;
          end else begin
            buf_w = buffer;
            av    = avail;
            ok    = 1;
            if (av < rq.len) begin
              ok = fetch(rd_pos, buf_w);
              av = 64;
            end
            if (!ok) begin
              r.status = bwr_pkg::ST_RANGE;
            end else begin
              r.value = buf_w & ((64'd1 << rq.len) - 64'd1);
              buffer  = buf_w >> rq.len;
              avail   = av - rq.len;
              rd_pos  = rd_pos + rq.len;
            end
          end
        end
        bwr_pkg::CMD_UNARY: begin
          buf_w = buffer;
          av    = avail;
          pos   = rd_pos;
          zeros = '0;
          ok    = 1;
          while (buf_w == '0) begin
            pos   += av;
            zeros += av;
            if (!fetch(pos, buf_w)) begin
              ok = 0;
              break;
            end
            av = 64;
          end
          if (!ok) begin
            r.status = bwr_pkg::ST_RANGE;
          end else begin
            l       = lowest_one(buf_w);
            buffer  = (buf_w >> l) >> 1;
            // saturates when the buffer held bits above the count
            avail   = (av >= l + 1) ? av - (l + 1) : 0;
            rd_pos  = pos + l + 1;
            r.value = zeros + l;
          end
        end
        bwr_pkg::CMD_NEXT: begin
          buf_w = buffer;
          pos   = rd_pos;
          ok    = 1;
          while (buf_w == '0) begin
            pos += 64;
            if ((pos >> 6) >= live_words()) begin
              ok = 0;
              break;
            end
            buf_w = words[pos >> 6];
          end
          if (!ok) begin
            r.status = bwr_pkg::ST_RANGE;
          end else begin
            buffer = buf_w & (buf_w - 64'd1);
            rd_pos = (pos & ~32'd63) + lowest_one(buf_w);
          end
        end
        default: ;
      endcase
      r.bit_position = rd_pos[16:0];
      pending_results.push_back(r);
    endfunction

    task report(string what);
      $display("mismatch: %s", what);
      mismatches++;
    endtask

    task check_result(logic [63:0] v, logic [16:0] p, logic [1:0] s);
      reader_result_t e;
      if (pending_results.size() == 0) begin
        report($sformatf("unexpected result value %h pos %0d status %0d", v, p, s));
      end else begin
        e = pending_results.pop_front();
        if (v !== e.value)
          report($sformatf("value %h, expected %h", v, e.value));
        if (p !== e.bit_position)
          report($sformatf("bit_position %0d, expected %0d", p, e.bit_position));
        if (s !== e.status)
          report($sformatf("status %0d, expected %0d", s, e.status));
      end
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  cmd;
  logic [9:0]  word_address;
  logic [63:0] word_data;
  logic [6:0]  field_length;
  logic [15:0] seek_position;
  logic        out_valid;
  logic        out_stall;
  logic [63:0] value;
  logic [16:0] bit_position;
  logic [1:0]  status;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  reader_scoreboard sb;
  bit               quiet;      // no idling on either side in the closing stretch
  int unsigned      stall_left;

  bitstream_word_reader_top #(.STORE_WORDS(STORE_WORDS)) uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .cmd_i           (cmd),
    .word_address_i  (word_address),
    .word_data_i     (word_data),
    .field_length_i  (field_length),
    .seek_position_i (seek_position),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .value_o         (value),
    .bit_position_o  (bit_position),
    .status_o        (status),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // generous limit; the slowest legal run stays far below this
  initial begin
    #40000000;
    $display("bitstream_word_reader_top_tb NOT OK");
    $finish;
  end

  // receiver stalls in random bursts of random length
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 11);
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // outputs are stable at the falling edge and hold to the next rising edge
  always @(negedge clk_i) begin
    if (rst_ni && out_valid && !out_stall)
      sb.check_result(value, bit_position, status);
  end

  // random word, often sparse or zero so that scans cross words
  function automatic logic [63:0] stream_word();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return 64'd1 << $urandom_range(0, 63);
      2:       return {$urandom, $urandom};
      3:       return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
      4:       return {64{1'b1}};
      default: return ({$urandom, $urandom} & {$urandom, $urandom}) << $urandom_range(0, 63);
    endcase
  endfunction

  // one request: sometimes a random gap first, then hold valid until it is taken
  task send_request(logic [2:0] c, logic [9:0] a, logic [63:0] d, logic [6:0] l,
                    logic [15:0] s);
    word_request_t rq;
    bit            taken;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    in_valid      <= 1'b1;
    cmd           <= c;
    word_address  <= a;
    word_data     <= d;
    field_length  <= l;
    seek_position <= s;
    rq = '{c, a, d, l, s};
    taken = 0;
    while (!taken) begin
      @(negedge clk_i);
      taken = !in_stall;
      @(posedge clk_i);
    end
    sb.note_request(rq);
  endtask

  // drain every outstanding result, then let the executor settle
  task drain_results();
    in_valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task apb_write(logic [2:0] addr, logic [31:0] data);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr[2] == bwr_pkg::CFG_WORDS_IN_USE) sb.words_in_use = data[10:0];
    @(posedge clk_i);
  endtask

  // mostly well-formed commands aimed inside the live stream, some noise
  task random_request();
    int unsigned end_bits;
    int unsigned pick;
    logic [15:0] s;
    logic [6:0]  l;
    end_bits = sb.live_words() * 64;
    if (end_bits != 0 && $urandom_range(0, 9) != 0)
      s = 16'($urandom_range(0, end_bits - 1));
    else
      s = 16'($urandom);
    l = ($urandom_range(0, 9) == 0) ? 7'($urandom) : 7'($urandom_range(0, 63));
    pick = $urandom_range(0, 99);
    if (pick < 10)
      send_request(bwr_pkg::CMD_WRITE,
                   (sb.live_words() != 0 && $urandom_range(0, 3) != 0) ?
                     10'($urandom_range(0, sb.live_words() - 1)) : 10'($urandom),
                   stream_word(), 7'($urandom), 16'($urandom));
    else if (pick < 24)
      send_request(bwr_pkg::CMD_SEEK, 10'($urandom), {$urandom, $urandom}, l, s);
    else if (pick < 34)
      send_request(bwr_pkg::CMD_SEEK_AL, 10'($urandom), {$urandom, $urandom}, l, s);
    else if (pick < 64)
      send_request(bwr_pkg::CMD_FIXED, 10'($urandom), {$urandom, $urandom}, l, s);
    else if (pick < 80)
      send_request(bwr_pkg::CMD_UNARY, 10'($urandom), {$urandom, $urandom}, l, s);
    else if (pick < 96)
      send_request(bwr_pkg::CMD_NEXT, 10'($urandom), {$urandom, $urandom}, l, s);
    else
      send_request(3'($urandom_range(6, 7)), 10'($urandom), {$urandom, $urandom}, l, s);
  endtask

  int unsigned phase_words[$];

  initial begin
    sb            = new();
    quiet         = 0;
    stall_left    = 0;
    rst_ni        = 1'b0;
    in_valid      = 1'b0;
    cmd           = '0;
    word_address  = '0;
    word_data     = '0;
    field_length  = '0;
    seek_position = '0;
    out_stall     = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // every store entry is written before any read can reach it
    for (int i = 0; i < STORE_WORDS; i++)
      send_request(bwr_pkg::CMD_WRITE, 10'(i), stream_word(), '0, '0);

    // directed: field extremes, every command, the corner cases
    send_request(bwr_pkg::CMD_WRITE, 10'd1023, {64{1'b1}}, 7'd127, 16'hffff);
    send_request(bwr_pkg::CMD_WRITE, 10'd0, 64'h8000_0000_0000_0001, '0, '0);
    send_request(bwr_pkg::CMD_SEEK, '0, '0, '0, 16'd0);
    send_request(bwr_pkg::CMD_FIXED, '0, '0, 7'd0, '0);
    send_request(bwr_pkg::CMD_FIXED, '0, '0, 7'd63, '0);
    send_request(bwr_pkg::CMD_FIXED, '0, '0, 7'd64, '0);   // length too large
    send_request(bwr_pkg::CMD_FIXED, '0, '0, 7'd127, '0);
    send_request(bwr_pkg::CMD_SEEK, '0, '0, '0, 16'hffff);  // last bit of the stream
    send_request(bwr_pkg::CMD_FIXED, '0, '0, 7'd1, '0);
    send_request(bwr_pkg::CMD_FIXED, '0, '0, 7'd5, '0);    // served from the buffer past the end
    send_request(bwr_pkg::CMD_UNARY, '0, '0, '0, '0);
    send_request(bwr_pkg::CMD_NEXT, '0, '0, '0, '0);
    send_request(bwr_pkg::CMD_SEEK_AL, '0, '0, '0, 16'hffff);
    send_request(bwr_pkg::CMD_NEXT, '0, '0, '0, '0);
    send_request(bwr_pkg::CMD_NEXT, '0, '0, '0, '0);       // search runs off the end
    send_request(3'd6, {10{1'b1}}, {64{1'b1}}, 7'd127, 16'hffff);
    send_request(3'd7, '0, '0, '0, '0);
    // aligned seek leaves the count at zero with bits above it: unary saturates
    send_request(bwr_pkg::CMD_SEEK, '0, '0, '0, 16'd0);
    send_request(bwr_pkg::CMD_SEEK_AL, '0, '0, '0, 16'd0);
    send_request(bwr_pkg::CMD_UNARY, '0, '0, '0, '0);
    send_request(bwr_pkg::CMD_NEXT, '0, '0, '0, '0);
    send_request(bwr_pkg::CMD_FIXED, '0, '0, 7'd10, '0);
    drain_results();

    // ignored register index, then a sweep of stream lengths
    apb_write(3'd4, 32'd7);
    phase_words = '{0, 2047, 1, 2, 3, 8, $urandom_range(4, 40), 1024};
    foreach (phase_words[ph]) begin
      apb_write(3'd0, phase_words[ph]);
      for (int n = 0; n < 20; n++) begin
        if (ph == phase_words.size() - 1 && n == 10) quiet = 1;
        random_request();
      end
      drain_results();
    end

    if (sb.mismatches == 0)
      $display("bitstream_word_reader_top_tb OK");
    else
      $display("bitstream_word_reader_top_tb NOT OK");
    $finish;
  end

endmodule
`default_nettype wire

>>> filelist.f
+incdir+rtl
rtl/bwr_pkg.sv
rtl/bwr_ram.sv
rtl/bwr_front.sv
rtl/bwr_back.sv
rtl/bitstream_word_reader_top.sv
rtl/bwr_checker.sv
sim/bitstream_word_reader_top_tb.sv
